/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files of the CSV city record parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication: whenever the antecedent holds, the consequent must hold too.
`define CVP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `CVP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/core/cvp_pkg.sv */
// Shared types, constants and helpers for the CSV city record parser.
package cvp_pkg;

  localparam int unsigned MAX_CITY_LEN = 255;
  localparam int unsigned BKT_W        = 16;
  localparam int unsigned DIV_STEPS    = BKT_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_ADDR_W   = 3;

  localparam logic [BKT_W-1:0] BUCKET_RESET = 16'd400;
  localparam logic [30:0]      POP_MAX      = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_PAREN = 8'd40;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Register index of bucket_count, taken from paddr[2].
  localparam logic CFG_IDX_BUCKET = 1'b0;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_RANK    = 4'd1,
    PH_OPENQ   = 4'd2,
    PH_CITY    = 4'd3,
    PH_SEP     = 4'd4,
    PH_POPOPEN = 4'd5,
    PH_POP     = 4'd6,
    PH_DONE    = 4'd10,
    PH_BAD     = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LEN,
    SQ_SUM,
    SQ_PROD,
    SQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_SATURATED = 2'd2
  } rec_status_t;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_RECORD = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic             start;
    logic [BKT_W-1:0] dividend;
    logic [BKT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BKT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/core/cvp_mod_unit.sv */
// Iterative restoring modulo unit: one remainder bit per cycle.
module cvp_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  cvp_pkg::div_req_t req,
  output cvp_pkg::div_rsp_t rsp
);
  import cvp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BKT_W-1:0]     rem_r, rem_nxt;
  logic [BKT_W-1:0]     dvd_r, dvd_nxt;
  logic [BKT_W-1:0]     dsr_r, dsr_nxt;
  logic [BKT_W:0]       shifted;
  logic [BKT_W+1:0]     diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[BKT_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // Subtract when the shifted partial remainder reaches the divisor.
      rem_nxt = diff[BKT_W+1] ? shifted[BKT_W-1:0] : diff[BKT_W-1:0];
      dvd_nxt = {dvd_r[BKT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

/* rtl/core/csv_city_record_parser.sv */
// Top level of the CSV city record parser: line parser, sequencer and output register.
// The block takes one byte of a text line per item and checks it against the form
// rank digits, comma, quoted city, comma, then a quoted population of digits and
// commas or an opening parenthesis that means zero. Each city byte comes out as a
// character item; the line feed produces one record item with status, population,
// city length and three bucket indexes (length, byte sum, product of the first two
// bytes) taken modulo bucket_count. A byte that produces no item is taken while the
// sequencer is idle, and the next byte may follow right away. A city byte is parsed
// and then moved into the output register, after any stall on the output clears.
// A line feed on a malformed line takes the same path. A line feed that closes
// a good line first runs the single shared modulo unit, which produces one
// remainder bit per cycle, three times in turn (length, byte sum, product), and
// then loads the record into the output register. bucket_count is written through the
// APB port at byte address 0; the user must write it only while the block is idle,
// which the block itself does not enforce; a bucket_count of zero gives bucket indexes of zero.
module csv_city_record_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input byte channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_char_code,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_result_kind,
  output logic [7:0]                       out_city_char,
  output logic [1:0]                       out_record_status,
  output logic [30:0]                      out_population,
  output logic [7:0]                       out_city_length,
  output logic [cvp_pkg::BKT_W-1:0]        out_length_bucket,
  output logic [cvp_pkg::BKT_W-1:0]        out_sum_bucket,
  output logic [cvp_pkg::BKT_W-1:0]        out_product_bucket,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cvp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import cvp_pkg::*;

  // Sequencer and line state.
  seq_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [30:0]      pop_r, pop_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       second_r, second_nxt;
  logic             sat_r, sat_nxt;
  logic [7:0]       char_r, char_nxt;
  res_kind_t        pend_kind_r, pend_kind_nxt;
  logic [BKT_W-1:0] bucket_count_r;
  logic [BKT_W-1:0] len_bkt_r, len_bkt_nxt;
  logic [BKT_W-1:0] sum_bkt_r, sum_bkt_nxt;
  logic [BKT_W-1:0] prod_bkt_r, prod_bkt_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  res_kind_t        out_kind_r, out_kind_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  rec_status_t      out_status_r, out_status_nxt;
  logic [30:0]      out_pop_r, out_pop_nxt;
  logic [7:0]       out_len_r, out_len_nxt;
  logic [BKT_W-1:0] out_lbkt_r, out_lbkt_nxt;
  logic [BKT_W-1:0] out_sbkt_r, out_sbkt_nxt;
  logic [BKT_W-1:0] out_pbkt_r, out_pbkt_nxt;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [BKT_W-1:0] div_bucket;
  logic [34:0]      pop_ext;
  logic [34:0]      pop_step;
  logic             cfg_wr;

  cvp_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // A zero bucket count maps every index to zero.
  assign div_bucket = (bucket_count_r == '0) ? '0 : div_rsp.remainder;

  // Population times ten plus the new digit, with headroom to detect overflow.
  assign pop_ext  = 35'(pop_r);
  assign pop_step = (pop_ext << 3) + (pop_ext << 1) + 35'(in_char_code - CH_ZERO);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    pop_nxt        = pop_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    sat_nxt        = sat_r;
    char_nxt       = char_r;
    pend_kind_nxt  = pend_kind_r;
    len_bkt_nxt    = len_bkt_r;
    sum_bkt_nxt    = sum_bkt_r;
    prod_bkt_nxt   = prod_bkt_r;
    div_req.start    = 1'b0;
    div_req.dividend = {8'd0, count_r};
    div_req.divisor  = bucket_count_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    out_len_nxt    = out_len_r;
    out_lbkt_nxt   = out_lbkt_r;
    out_sbkt_nxt   = out_sbkt_r;
    out_pbkt_nxt   = out_pbkt_r;

    case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          char_nxt = in_char_code;
          if (in_char_code == CH_LF) begin
            pend_kind_nxt = KIND_RECORD;
            if (phase_r == PH_DONE) begin
              // Good line: run the three modulo passes before the record goes out.
              div_req.start = 1'b1;
              state_nxt     = SQ_LEN;
            end else begin
              state_nxt = SQ_OUT;
            end
          end else begin
            case (phase_r)
              PH_START: phase_nxt = is_digit(in_char_code) ? PH_RANK : PH_BAD;
              PH_RANK: begin
                if (in_char_code == CH_COMMA) begin
                  phase_nxt = PH_OPENQ;
                end else if (!is_digit(in_char_code)) begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_OPENQ: phase_nxt = (in_char_code == CH_QUOTE) ? PH_CITY : PH_BAD;
              PH_CITY: begin
                if (in_char_code == CH_QUOTE) begin
                  phase_nxt = PH_SEP;
                end else begin
                  // Bytes past the length limit pass through uncounted.
                  if (count_r >= 8'(MAX_CITY_LEN)) begin
                    sat_nxt = 1'b1;
                  end else begin
                    if (count_r == 8'd0) begin
                      first_nxt = in_char_code;
                    end else if (count_r == 8'd1) begin
                      second_nxt = in_char_code;
                    end
                    sum_nxt   = sum_r + 16'(in_char_code);
                    count_nxt = count_r + 8'd1;
                  end
                  pend_kind_nxt = KIND_CHAR;
                  state_nxt     = SQ_OUT;
                end
              end
              PH_SEP: phase_nxt = (in_char_code == CH_COMMA) ? PH_POPOPEN : PH_BAD;
              PH_POPOPEN: begin
                pop_nxt = '0;
                if (in_char_code == CH_QUOTE) begin
                  phase_nxt = PH_POP;
                end else if (in_char_code == CH_PAREN) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_BAD;
                  pop_nxt   = pop_r;
                end
              end
              PH_POP: begin
                if (is_digit(in_char_code)) begin
                  if (pop_step > 35'(POP_MAX)) begin
                    pop_nxt = POP_MAX;
                    sat_nxt = 1'b1;
                  end else begin
                    pop_nxt = pop_step[30:0];
                  end
                end else if (in_char_code == CH_QUOTE) begin
                  phase_nxt = PH_DONE;
                end else if (in_char_code != CH_COMMA) begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_DONE, PH_BAD: phase_nxt = phase_r;
              default: phase_nxt = PH_BAD;
            endcase
          end
        end
      end
      SQ_LEN: begin
        if (div_rsp.done) begin
          len_bkt_nxt      = div_bucket;
          div_req.start    = 1'b1;
          div_req.dividend = sum_r;
          state_nxt        = SQ_SUM;
        end
      end
      SQ_SUM: begin
        if (div_rsp.done) begin
          sum_bkt_nxt      = div_bucket;
          div_req.start    = 1'b1;
          div_req.dividend = 16'(first_r) * 16'(second_r);
          state_nxt        = SQ_PROD;
        end
      end
      SQ_PROD: begin
        if (div_rsp.done) begin
          // The output register may still hold a stalled item, so park the result.
          prod_bkt_nxt = div_bucket;
          state_nxt    = SQ_OUT;
        end
      end
      SQ_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_char_nxt   = '0;
          out_status_nxt = ST_OK;
          out_pop_nxt    = '0;
          out_len_nxt    = '0;
          out_lbkt_nxt   = '0;
          out_sbkt_nxt   = '0;
          out_pbkt_nxt   = '0;
          if (pend_kind_r == KIND_CHAR) begin
            out_char_nxt = char_r;
          end else begin
            if (phase_r == PH_DONE) begin
              out_status_nxt = sat_r ? ST_SATURATED : ST_OK;
              out_pop_nxt    = pop_r;
              out_len_nxt    = count_r;
              out_lbkt_nxt   = len_bkt_r;
              out_sbkt_nxt   = sum_bkt_r;
              out_pbkt_nxt   = prod_bkt_r;
            end else begin
              out_status_nxt = ST_MALFORMED;
            end
            // The record closes the line, so all line state starts over.
            phase_nxt  = PH_START;
            pop_nxt    = '0;
            count_nxt  = '0;
            sum_nxt    = '0;
            first_nxt  = '0;
            second_nxt = '0;
            sat_nxt    = 1'b0;
          end
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      phase_r     <= PH_START;
      pop_r       <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pop_r       <= pop_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r       <= char_nxt;
    pend_kind_r  <= pend_kind_nxt;
    len_bkt_r    <= len_bkt_nxt;
    sum_bkt_r    <= sum_bkt_nxt;
    prod_bkt_r   <= prod_bkt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_len_r    <= out_len_nxt;
    out_lbkt_r   <= out_lbkt_nxt;
    out_sbkt_r   <= out_sbkt_nxt;
    out_pbkt_r   <= out_pbkt_nxt;
  end

  // Configuration register: a write lands in the access phase.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_BUCKET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_RESET;
    end else if (cfg_wr) begin
      bucket_count_r <= pwdata[BKT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_BUCKET) ? {16'd0, bucket_count_r} : 32'd0;
  assign pready = 1'b1;

  // Bytes are taken only while the sequencer is idle.
  assign in_stall = (state_r != SQ_IDLE);

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_city_char      = out_char_r;
  assign out_record_status  = out_status_r;
  assign out_population     = out_pop_r;
  assign out_city_length    = out_len_r;
  assign out_length_bucket  = out_lbkt_r;
  assign out_sum_bucket     = out_sbkt_r;
  assign out_product_bucket = out_pbkt_r;

  `include "assert_macros.svh"

  // The modulo unit only finishes while the sequencer waits on it.
  `CVP_ASSERT_IMPLIES(a_done_in_mod_state, div_rsp.done, (state_r == SQ_LEN) || (state_r == SQ_SUM) || (state_r == SQ_PROD), "modulo result arrived outside a modulo step")
  // No byte is taken while the modulo unit is still working.
  `CVP_ASSERT_IMPLIES(a_idle_unit_free, !in_stall, !div_rsp.busy, "input open while the modulo unit is busy")
  // Every bucket index of a pending item stays below a nonzero bucket count.
  `CVP_ASSERT(a_bucket_range, (out_valid && (bucket_count_r != '0)) |-> ((out_length_bucket < bucket_count_r) && (out_sum_bucket < bucket_count_r) && (out_product_bucket < bucket_count_r)), "bucket index not below bucket count")

endmodule
